// ----- rtl/core/asg_pkg.sv -----
// shared types, codes and constants of the sawtooth generator
package asg_pkg;

  // field and state widths
  localparam int unsigned ValW   = 10;
  localparam int unsigned LevelW = 11;
  localparam int unsigned KeyW   = 3;
  localparam int unsigned IdxW   = 3;

  // default converter width
  localparam int unsigned DacBitsDefault = 10;

  // divider iterations, one quotient bit each
  localparam int unsigned DivSteps = ValW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // request types
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  // key codes
  localparam logic [KeyW-1:0] KEY_NONE       = 3'd0;
  localparam logic [KeyW-1:0] KEY_AMP_UP     = 3'd1;
  localparam logic [KeyW-1:0] KEY_AMP_DOWN   = 3'd2;
  localparam logic [KeyW-1:0] KEY_PERIOD_UP  = 3'd3;
  localparam logic [KeyW-1:0] KEY_PERIOD_DN  = 3'd4;

  // register indexes
  localparam logic [IdxW-1:0] REG_AMP_STEP    = 3'd0;
  localparam logic [IdxW-1:0] REG_AMP_MIN     = 3'd1;
  localparam logic [IdxW-1:0] REG_AMP_MAX     = 3'd2;
  localparam logic [IdxW-1:0] REG_PERIOD_STEP = 3'd3;
  localparam logic [IdxW-1:0] REG_PERIOD_MIN  = 3'd4;
  localparam logic [IdxW-1:0] REG_PERIOD_MAX  = 3'd5;

  // reset values
  localparam logic [ValW-1:0] AmpStepRst    = 10'd155;
  localparam logic [ValW-1:0] AmpMinRst     = 10'd155;
  localparam logic [ValW-1:0] AmpMaxRst     = 10'd1023;
  localparam logic [ValW-1:0] PeriodStepRst = 10'd10;
  localparam logic [ValW-1:0] PeriodMinRst  = 10'd10;
  localparam logic [ValW-1:0] PeriodMaxRst  = 10'd300;
  localparam logic [ValW-1:0] AmplitudeRst  = 10'd465;
  localparam logic [ValW-1:0] PeriodRst     = 10'd10;

  // period saturation bounds
  localparam logic [ValW-1:0] PeriodCeil  = 10'd1023;
  localparam logic [ValW-1:0] PeriodFloor = 10'd1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic commit_tick;
    logic commit_key;
  } asg_cmd_t;

endpackage

// ----- rtl/core/asg_if.sv -----
// valid/ready channel interfaces for requests and results
interface asg_req_if import asg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [KeyW-1:0] key_code;

  modport source (output valid, output req_type, output key_code, input ready);
  modport sink   (input valid, input req_type, input key_code, output ready);
endinterface

interface asg_res_if import asg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            sample_valid;
  logic [ValW-1:0] dac_value;
  logic [KeyW-1:0] toggle_led;
  logic [ValW-1:0] amplitude_now;
  logic [ValW-1:0] period_now;

  modport source (output valid, output sample_valid, output dac_value, output toggle_led,
                  output amplitude_now, output period_now, input ready);
  modport sink   (input valid, input sample_valid, input dac_value, input toggle_led,
                  input amplitude_now, input period_now, output ready);
endinterface

// ----- rtl/core/asg_ctrl.sv -----
// sequencing state machine of the sawtooth generator
module asg_ctrl import asg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_type_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output asg_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            is_tick_q, is_tick_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    is_tick_d = is_tick_q;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          is_tick_d  = (in_type_i == REQ_TICK);
          cnt_d      = '0;
          state_d    = (in_type_i == REQ_TICK) ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.commit_tick = is_tick_q;
          cmd_o.commit_key  = !is_tick_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit_tick || cmd_o.commit_key) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      is_tick_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      is_tick_q   <= is_tick_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/asg_dpath.sv -----
// settings, divider, level counter and result register of the generator
module asg_dpath import asg_pkg::*; #(
  parameter int unsigned DAC_BITS = DacBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  asg_cmd_t        cmd_i,
  input  logic [KeyW-1:0] key_code_i,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [ValW-1:0] cfg_data_i,
  output logic            sample_valid_o,
  output logic [ValW-1:0] dac_value_o,
  output logic [KeyW-1:0] toggle_led_o,
  output logic [ValW-1:0] amplitude_now_o,
  output logic [ValW-1:0] period_now_o
);

  localparam int unsigned CmpW   = 17;
  localparam logic [CmpW-1:0] DacMax = CmpW'((32'd1 << DAC_BITS) - 32'd1);

  logic [ValW-1:0]   amp_step_q, amp_min_q, amp_max_q;
  logic [ValW-1:0]   per_step_q, per_min_q, per_max_q;
  logic [LevelW-1:0] level_q, level_d;
  logic [ValW-1:0]   amp_q, amp_d;
  logic [ValW-1:0]   per_q, per_d;
  logic [KeyW-1:0]   led_q, led_d;
  logic [KeyW-1:0]   key_q;
  logic [ValW-1:0]   rem_q, quo_q;

  logic [ValW:0]     rem_sh, rem_sub;
  logic              fits;
  logic [LevelW-1:0] tick_sum;
  logic              wrap;
  logic [ValW:0]     amp_up_sum, per_up_sum;
  logic [ValW-1:0]   amp_up_val, amp_dn_val, per_up_val, per_dn_val;
  logic              key_ok;
  logic [KeyW-1:0]   toggle_d;
  logic [ValW-1:0]   dac_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_step_q <= AmpStepRst;
      amp_min_q  <= AmpMinRst;
      amp_max_q  <= AmpMaxRst;
      per_step_q <= PeriodStepRst;
      per_min_q  <= PeriodMinRst;
      per_max_q  <= PeriodMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AMP_STEP:    amp_step_q <= cfg_data_i;
        REG_AMP_MIN:     amp_min_q  <= cfg_data_i;
        REG_AMP_MAX:     amp_max_q  <= cfg_data_i;
        REG_PERIOD_STEP: per_step_q <= cfg_data_i;
        REG_PERIOD_MIN:  per_min_q  <= cfg_data_i;
        REG_PERIOD_MAX:  per_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // restoring divider step, amplitude over period
  assign rem_sh  = {rem_q, quo_q[ValW-1]};
  assign fits    = (rem_sh >= {1'b0, per_q});
  assign rem_sub = rem_sh - {1'b0, per_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_code_i;
      rem_q <= '0;
      quo_q <= amp_q;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? rem_sub[ValW-1:0] : rem_sh[ValW-1:0];
      quo_q <= {quo_q[ValW-2:0], fits};
    end
  end

  // tick: advance the level, wrap past the amplitude
  assign tick_sum = level_q + LevelW'(quo_q);
  assign wrap     = (tick_sum > LevelW'(amp_q));

  // key candidates with saturation
  assign amp_up_sum = {1'b0, amp_q} + {1'b0, amp_step_q};
  assign amp_up_val = (amp_up_sum > {1'b0, amp_max_q}) ? amp_max_q : amp_up_sum[ValW-1:0];
  assign amp_dn_val = (amp_step_q >= amp_q) ? '0 : amp_q - amp_step_q;
  assign per_up_sum = {1'b0, per_q} + {1'b0, per_step_q};
  assign per_up_val = (per_up_sum > {1'b0, PeriodCeil}) ? PeriodCeil : per_up_sum[ValW-1:0];
  assign per_dn_val = (per_step_q >= per_q) ? PeriodFloor : per_q - per_step_q;

  // next state of level, settings and led selection
  always_comb begin
    level_d  = level_q;
    amp_d    = amp_q;
    per_d    = per_q;
    led_d    = led_q;
    key_ok   = 1'b0;
    toggle_d = KEY_NONE;
    if (cmd_i.commit_tick) begin
      level_d  = wrap ? '0 : tick_sum;
      toggle_d = wrap ? led_q : KEY_NONE;
    end else if (cmd_i.commit_key) begin
      unique case (key_q)
        KEY_AMP_UP: begin
          key_ok = (amp_q < amp_max_q);
          if (key_ok) amp_d = amp_up_val;
        end
        KEY_AMP_DOWN: begin
          key_ok = (amp_q > amp_min_q);
          if (key_ok) amp_d = amp_dn_val;
        end
        KEY_PERIOD_UP: begin
          key_ok = (per_q < per_max_q);
          if (key_ok) per_d = per_up_val;
        end
        KEY_PERIOD_DN: begin
          key_ok = (per_q > per_min_q);
          if (key_ok) per_d = per_dn_val;
        end
        default: key_ok = 1'b0;
      endcase
      if (key_ok) begin
        level_d = '0;
        led_d   = key_q;
      end
    end
  end

  // converter clamp
  assign dac_d = (CmpW'(level_d) > DacMax) ? DacMax[ValW-1:0] : level_d[ValW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      amp_q   <= AmplitudeRst;
      per_q   <= PeriodRst;
      led_q   <= KEY_NONE;
    end else begin
      level_q <= level_d;
      amp_q   <= amp_d;
      per_q   <= per_d;
      led_q   <= led_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_tick || cmd_i.commit_key) begin
      sample_valid_o  <= cmd_i.commit_tick;
      dac_value_o     <= dac_d;
      toggle_led_o    <= toggle_d;
      amplitude_now_o <= amp_d;
      period_now_o    <= per_d;
    end
  end

endmodule

// ----- rtl/core/adjustable_sawtooth_generator.sv -----
// top level of the adjustable sawtooth generator
//
// Usage: requests enter on the req channel (valid/ready); each transaction
// is either a timer tick or a key event. Every request yields exactly one
// transaction on the res channel carrying the DAC sample, the LED to toggle
// on a wrap, and the current amplitude and period settings.
// A tick result passes through the restoring divider, which forms
// amplitude / period one quotient bit per cycle; the level is then
// updated and the result loaded. The next request can be taken in the
// cycle after the result is loaded.
// A key event skips the divider and its result is loaded directly.
// One request is in flight at a time.
// The result sits in an output register, so a new request is accepted
// while the previous result waits; if the receiver keeps stalling, the
// block holds the finished result in its final state until the register
// frees up, and req.ready stays low meanwhile.
// Reset (rst_ni low, asynchronous) clears the level, selects no LED, sets
// amplitude 465 and period 10 and loads the register defaults.
// Settings are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them while no
// request is in flight, the block itself does not enforce it; writes take effect at the next clock edge.
module adjustable_sawtooth_generator import asg_pkg::*; #(
  parameter int unsigned DAC_BITS = DacBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  asg_req_if.sink         req,
  asg_res_if.source       res,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [ValW-1:0] cfg_data_i
);

  asg_cmd_t cmd;

  // sequencing
  asg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_type_i   (req.req_type),
    .in_ready_o  (req.ready),
    .out_ready_i (res.ready),
    .out_valid_o (res.valid),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  asg_dpath #(
    .DAC_BITS (DAC_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .key_code_i      (req.key_code),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sample_valid_o  (res.sample_valid),
    .dac_value_o     (res.dac_value),
    .toggle_led_o    (res.toggle_led),
    .amplitude_now_o (res.amplitude_now),
    .period_now_o    (res.period_now)
  );

  // a result is only loaded into a free output register
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit_tick || cmd.commit_key) |-> (!res.valid || res.ready))
    else $error("result loaded over an untaken result");

  // tick and key commits are exclusive
  a_commit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.commit_tick && cmd.commit_key))
    else $error("tick and key commit together");

  // period never reaches zero
  a_period_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (res.period_now != '0))
    else $error("period is zero");

  // level never exceeds the amplitude
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (res.dac_value <= res.amplitude_now))
    else $error("sample above amplitude");

endmodule
